@@ rtl/ufd_pkg.sv @@
// shared types, constants and helper functions of the form decoder
package ufd_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int PAIR_COUNT_WIDTH    = 16;
   localparam int BYTE_WIDTH          = 8;

   localparam logic [BYTE_WIDTH-1:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_AMP     = 8'h26;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CASE_OFFSET  = 8'd32;
   localparam logic [BYTE_WIDTH-1:0] HEX_OFFSET   = 8'd10;
   localparam logic [BYTE_WIDTH-1:0] HIGH_BYTE    = 8'h80;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_KEY_END   = 2'd1,
      KIND_VALUE_END = 2'd2,
      KIND_DONE      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_NORMAL,
      PHASE_PERCENT,
      PHASE_DIGIT
   } phase_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] in_byte;
      logic                  is_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]       out_byte;
      kind_type                    kind;
      logic                        last;
      logic [PAIR_COUNT_WIDTH-1:0] pair_count;
      logic                        count_error;
   } rsp_type;

   // up to two results caused by one input item, in order
   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [BYTE_WIDTH-1:0] digit_value(input logic [BYTE_WIDTH-1:0] c);
      logic [BYTE_WIDTH-1:0] low;
      low = c;
      if (c <= CHAR_NINE || c >= HIGH_BYTE) begin
         return c - CHAR_ZERO;
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         low = c + CASE_OFFSET;
      end
      return low - CHAR_LOWER_A + HEX_OFFSET;
   endfunction

   function automatic rsp_type make_rsp(input kind_type kind,
                                        input logic [BYTE_WIDTH-1:0] data);
      rsp_type r;
      r.out_byte    = data;
      r.kind        = kind;
      r.last        = 1'b0;
      r.pair_count  = '0;
      r.count_error = 1'b0;
      return r;
   endfunction

endpackage

@@ rtl/ufd_stream_if.sv @@
// valid/ready stream channel with a typed payload
interface ufd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/ufd_front.sv @@
// front end: tracks escapes and counters, turns bytes and string ends into result jobs
module ufd_front #(
   parameter int COUNT_WIDTH = ufd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ufd_pkg::req_type          req_payload,
   input  ufd_pkg::queue_status_type queue_status,
   output logic                      push,
   output ufd_pkg::job_type          push_job
);
   import ufd_pkg::*;

   typedef struct packed {
      logic                  emit;
      kind_type              kind;
      logic [BYTE_WIDTH-1:0] data;
      logic                  key_inc;
      logic                  value_inc;
      logic                  opens;
   } plain_type;

   function automatic plain_type classify(input logic [BYTE_WIDTH-1:0] c);
      plain_type p;
      p.emit      = 1'b1;
      p.kind      = KIND_DATA;
      p.data      = c;
      p.key_inc   = 1'b0;
      p.value_inc = 1'b0;
      p.opens     = 1'b0;
      priority if (c == CHAR_EQUAL) begin
         p.kind    = KIND_KEY_END;
         p.data    = '0;
         p.key_inc = 1'b1;
      end else if (c == CHAR_AMP) begin
         p.kind      = KIND_VALUE_END;
         p.data      = '0;
         p.value_inc = 1'b1;
      end else if (c == CHAR_PLUS) begin
         p.data = CHAR_SPACE;
      end else if (c == CHAR_PERCENT) begin
         p.emit  = 1'b0;
         p.opens = 1'b1;
      end else begin
         p.data = c;
      end
      return p;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + COUNT_WIDTH'(1);
   endfunction

   phase_type              phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0]  held_ff, held_in;
   logic [COUNT_WIDTH-1:0] key_ff, key_in;
   logic [COUNT_WIDTH-1:0] value_ff, value_in;
   logic                   seen_ff, seen_in;

   logic                        accept;
   plain_type                   cur_plain;
   plain_type                   held_plain;
   logic [COUNT_WIDTH-1:0]      key_mid;
   logic [COUNT_WIDTH-1:0]      value_mid;
   logic [COUNT_WIDTH-1:0]      value_fin;
   logic [PAIR_COUNT_WIDTH-1:0] pair_sat;
   job_type                     job;

   assign req_ready  = !queue_status.full;
   assign accept     = req_valid && req_ready;
   assign cur_plain  = classify(req_payload.in_byte);
   assign held_plain = classify(held_ff);

   // held digit replayed as an ordinary byte when the end cuts an escape
   always_comb begin
      key_mid   = key_ff;
      value_mid = value_ff;
      if (phase_ff == PHASE_DIGIT) begin
         if (held_plain.key_inc) begin
            key_mid = sat_inc(key_ff);
         end
         if (held_plain.value_inc) begin
            value_mid = sat_inc(value_ff);
         end
      end
      value_fin = sat_inc(value_mid);
   end

   generate
      if (COUNT_WIDTH > PAIR_COUNT_WIDTH) begin : g_pair_sat
         assign pair_sat = (|key_mid[COUNT_WIDTH-1:PAIR_COUNT_WIDTH]) ?
                           '1 : key_mid[PAIR_COUNT_WIDTH-1:0];
      end else begin : g_pair_ext
         assign pair_sat = PAIR_COUNT_WIDTH'(key_mid);
      end
   endgenerate

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_payload.is_end) begin
            phase_in = PHASE_NORMAL;
         end else begin
            unique case (phase_ff)
               PHASE_PERCENT: phase_in = PHASE_DIGIT;
               PHASE_DIGIT:   phase_in = PHASE_NORMAL;
               PHASE_NORMAL:  phase_in = cur_plain.opens ? PHASE_PERCENT : PHASE_NORMAL;
               default:       phase_in = PHASE_NORMAL;
            endcase
         end
      end
   end

   // job, counters and held byte
   always_comb begin
      held_in  = held_ff;
      key_in   = key_ff;
      value_in = value_ff;
      seen_in  = seen_ff;
      job.first_valid  = 1'b0;
      job.first        = make_rsp(KIND_DATA, '0);
      job.second_valid = 1'b0;
      job.second       = make_rsp(KIND_DATA, '0);
      if (req_payload.is_end) begin
         if (!seen_ff) begin
            job.second_valid = 1'b1;
            job.second       = make_rsp(KIND_DONE, '0);
            job.second.last  = 1'b1;
         end else begin
            if (phase_ff == PHASE_DIGIT) begin
               job.first_valid = held_plain.emit;
               job.first       = make_rsp(held_plain.kind, held_plain.data);
            end
            job.second_valid       = 1'b1;
            job.second             = make_rsp(KIND_VALUE_END, '0);
            job.second.last        = 1'b1;
            job.second.pair_count  = pair_sat;
            job.second.count_error = (key_mid != value_fin);
         end
         held_in  = '0;
         key_in   = '0;
         value_in = '0;
         seen_in  = 1'b0;
      end else begin
         seen_in = 1'b1;
         unique case (phase_ff)
            PHASE_PERCENT: begin
               held_in = req_payload.in_byte;
            end
            PHASE_DIGIT: begin
               held_in         = '0;
               job.first_valid = 1'b1;
               job.first       = make_rsp(KIND_DATA,
                  (digit_value(held_ff) << 4) + digit_value(req_payload.in_byte));
            end
            PHASE_NORMAL: begin
               job.first_valid = cur_plain.emit;
               job.first       = make_rsp(cur_plain.kind, cur_plain.data);
               if (cur_plain.key_inc) begin
                  key_in = sat_inc(key_ff);
               end
               if (cur_plain.value_inc) begin
                  value_in = sat_inc(value_ff);
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   assign push     = accept && (job.first_valid || job.second_valid);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NORMAL;
         held_ff  <= '0;
         key_ff   <= '0;
         value_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            held_ff  <= held_in;
            key_ff   <= key_in;
            value_ff <= value_in;
            seen_ff  <= seen_in;
         end
      end
   end

endmodule

@@ rtl/ufd_queue.sv @@
// two-entry job queue between front and back
module ufd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ufd_pkg::job_type          push_job,
   input  logic                      pop,
   output ufd_pkg::job_type          head_job,
   output ufd_pkg::queue_status_type status
);
   import ufd_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/ufd_back.sv @@
// back end: unpacks queued jobs into single results behind an output register
module ufd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ufd_pkg::job_type          head_job,
   input  ufd_pkg::queue_status_type queue_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ufd_pkg::rsp_type          rsp_payload
);
   import ufd_pkg::*;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   logic    second_ff, second_in;
   logic    out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      second_in    = second_ff;
      pop          = 1'b0;
      if (out_free && !queue_status.empty) begin
         out_valid_in = 1'b1;
         if (head_job.first_valid && !second_ff) begin
            out_in = head_job.first;
            if (head_job.second_valid) begin
               second_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            // first already sent or absent
            out_in    = head_job.second;
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ rtl/urlencoded_form_decoder.sv @@
// top level of the form-urlencoded decoder
//
//   channel      dir   transaction
//   req_stream   in    one raw byte, or the end of the string (is_end)
//   rsp_stream   out   data byte, key end, value end or empty done, last marks
//                      the final result with pair count and count error
//
// one byte per cycle: the front takes a transaction every cycle while the
// two-entry job queue has room; rsp comes from the back's output register.
// an end that cuts an escape after its first digit can give two results, which
// the back sends in turn, so the output register sets the peak rate.
// synchronous reset clears the escape state, counters, queue and output valid.
// stalls on rsp back up through the queue to req ready.
module urlencoded_form_decoder #(
   parameter int COUNT_WIDTH = ufd_pkg::COUNT_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   ufd_stream_if.sink   req_stream,
   ufd_stream_if.source rsp_stream
);
   import ufd_pkg::*;

   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_status_type queue_status;

   ufd_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_stream.valid),
      .req_ready    (req_stream.ready),
      .req_payload  (req_stream.payload),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   ufd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   ufd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_stream.valid),
      .rsp_ready    (rsp_stream.ready),
      .rsp_payload  (rsp_stream.payload)
   );

endmodule

@@ verif/urlencoded_form_decoder_tb.sv @@
// self-checking testbench for the form-urlencoded decoder with a built-in decode predictor
module urlencoded_form_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufd_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_OFF_LEN = 300;

   logic clock = 1'b0;
   logic reset;

   ufd_stream_if #(.payload_type(req_type)) req_if ();
   ufd_stream_if #(.payload_type(rsp_type)) rsp_if ();

   urlencoded_form_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder state as the predictor sees it
   phase_type              esc_phase;
   logic [BYTE_WIDTH-1:0]  held_byte;
   logic [15:0]            key_total;
   logic [15:0]            value_total;
   logic                   byte_seen;
   rsp_type                pending_rsp[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_serial = 0;
   int hold_off_taken  = 0;
   int hold_left       = 0;
   int items_sent      = 0;
   int strings_sent    = 0;
   int results_checked = 0;
   int error_count     = 0;
   int cycle_count     = 0;

   function automatic rsp_type rsp_of(input kind_type k, input logic [BYTE_WIDTH-1:0] b,
                                      input logic l, input logic [15:0] pc,
                                      input logic err);
      rsp_type r;
      r.out_byte    = b;
      r.kind        = k;
      r.last        = l;
      r.pair_count  = pc;
      r.count_error = err;
      return r;
   endfunction

   function automatic logic [15:0] bump(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   // digits are never checked: anything maps to some value mod 256
   function automatic logic [BYTE_WIDTH-1:0] hex_nibble(input logic [BYTE_WIDTH-1:0] c);
      logic [BYTE_WIDTH-1:0] low;
      if (c <= CHAR_NINE || c >= HIGH_BYTE) return c - CHAR_ZERO;
      low = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
      return low - CHAR_LOWER_A + HEX_OFFSET;
   endfunction

   function automatic void clear_decode_state();
      esc_phase   = PHASE_NORMAL;
      held_byte   = '0;
      key_total   = '0;
      value_total = '0;
      byte_seen   = 1'b0;
   endfunction

   function automatic void plain_char(input logic [BYTE_WIDTH-1:0] c, input logic at_end);
      if (c == CHAR_EQUAL) begin
         key_total = bump(key_total);
         pending_rsp.push_back(rsp_of(KIND_KEY_END, '0, 1'b0, '0, 1'b0));
      end else if (c == CHAR_AMP) begin
         value_total = bump(value_total);
         pending_rsp.push_back(rsp_of(KIND_VALUE_END, '0, 1'b0, '0, 1'b0));
      end else if (c == CHAR_PLUS) begin
         pending_rsp.push_back(rsp_of(KIND_DATA, CHAR_SPACE, 1'b0, '0, 1'b0));
      end else if (c == CHAR_PERCENT) begin
         if (!at_end) esc_phase = PHASE_PERCENT;
      end else begin
         pending_rsp.push_back(rsp_of(KIND_DATA, c, 1'b0, '0, 1'b0));
      end
   endfunction

   function automatic void decode_step(input logic [BYTE_WIDTH-1:0] c, input logic at_end);
      logic [BYTE_WIDTH-1:0] d1;
      logic [BYTE_WIDTH-1:0] d2;
      if (!at_end) begin
         byte_seen = 1'b1;
         case (esc_phase)
            PHASE_PERCENT: begin
               held_byte = c;
               esc_phase = PHASE_DIGIT;
            end
            PHASE_DIGIT: begin
               d1 = hex_nibble(held_byte);
               d2 = hex_nibble(c);
               esc_phase = PHASE_NORMAL;
               held_byte = '0;
               pending_rsp.push_back(rsp_of(KIND_DATA, {d1[3:0], 4'h0} + d2, 1'b0, '0, 1'b0));
            end
            default: plain_char(c, 1'b0);
         endcase
      end else if (!byte_seen) begin
         pending_rsp.push_back(rsp_of(KIND_DONE, '0, 1'b1, '0, 1'b0));
         clear_decode_state();
      end else begin
         // escape cut after one digit: the digit falls back to a plain byte
         if (esc_phase == PHASE_DIGIT) plain_char(held_byte, 1'b1);
         value_total = bump(value_total);
         pending_rsp.push_back(rsp_of(KIND_VALUE_END, '0, 1'b1, key_total,
                                      key_total != value_total));
         clear_decode_state();
      end
   endfunction

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic at_end);
      req_type item;
      item.in_byte = b;
      item.is_end  = at_end;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      decode_step(b, at_end);
      items_sent++;
      if (at_end) strings_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [BYTE_WIDTH-1:0] hex_char();
      int d;
      d = $urandom_range(0, 21);
      if (d < 10) return CHAR_ZERO + 8'(d);
      if (d < 16) return CHAR_LOWER_A + 8'(d - 10);
      return CHAR_UPPER_A + 8'(d - 16);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] special_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_EQUAL;
         1:       return CHAR_AMP;
         2:       return CHAR_PLUS;
         default: return CHAR_PERCENT;
      endcase
   endfunction

   task automatic send_text_run(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            3:       send_byte(8'($urandom_range(8'h30, 8'h39)), 1'b0);
            4:       send_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
            5:       send_byte(CHAR_PLUS, 1'b0);
            6, 7: begin
               send_byte(CHAR_PERCENT, 1'b0);
               send_byte(hex_char(), 1'b0);
               send_byte(hex_char(), 1'b0);
            end
            8:       send_byte(8'($urandom_range(0, 255)), 1'b0);
            default: send_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
         endcase
      end
   endtask

   task automatic send_random_string();
      int pairs;
      int p;
      int k;
      int n;
      if ($urandom_range(0, 99) < 15) begin
         // noise: separators, escapes and raw bytes in any order
         n = $urandom_range(0, 12);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 1) != 0) send_byte(special_char(), 1'b0);
            else send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end else begin
         pairs = $urandom_range(0, 4);
         for (p = 0; p < pairs; p++) begin
            if (p != 0) send_byte(CHAR_AMP, 1'b0);
            send_text_run($urandom_range(0, 5));
            if ($urandom_range(0, 9) != 0) send_byte(CHAR_EQUAL, 1'b0);
            send_text_run($urandom_range(0, 6));
         end
         // now and then the end cuts an escape short
         case ($urandom_range(0, 9))
            0: send_byte(CHAR_PERCENT, 1'b0);
            1: begin
               send_byte(CHAR_PERCENT, 1'b0);
               if ($urandom_range(0, 1) != 0) send_byte(special_char(), 1'b0);
               else send_byte(hex_char(), 1'b0);
            end
            default: ;
         endcase
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_empty_string();
      send_byte(8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_plain_pairs();
      send_byte(8'h00, 1'b0);
      send_byte(CHAR_EQUAL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_PLUS, 1'b0);
      send_byte(CHAR_AMP, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_for_results();
   endtask

   task automatic test_escape_digits();
      // separators after '%' are taken as digits
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_EQUAL, 1'b0);
      send_byte(CHAR_AMP, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_UPPER_A, 1'b0);
      send_byte(8'h66, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_cut_escape();
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(CHAR_EQUAL, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_EQUAL, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      int k;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_serial++;
      // keep offering while the output is held off so the input stalls
      for (k = 0; k < 40; k++) send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      send_byte(CHAR_EQUAL, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);
      wait_for_results();
      send_byte(hex_char(), 1'b0);
      send_byte(hex_char(), 1'b0);
      send_byte(8'h00, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_strings(input int idle_pct, input int stall_pct, input int n);
      int start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start = items_sent;
      while (items_sent - start < n) send_random_string();
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (hold_off_serial != hold_off_taken) begin
         hold_off_taken <= hold_off_serial;
         hold_left      <= HOLD_OFF_LEN;
         rsp_if.ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      got = rsp_if.payload;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transaction: kind %0d out_byte %0h", got.kind,
                   got.out_byte);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            results_checked++;
            if (got.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
               error_count++;
            end
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, got.kind);
               error_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, got.last);
               error_count++;
            end
            if (got.pair_count !== want.pair_count) begin
               $error("pair_count: expected %0d, actual %0d", want.pair_count,
                      got.pair_count);
               error_count++;
            end
            if (got.count_error !== want.count_error) begin
               $error("count_error: expected %0d, actual %0d", want.count_error,
                      got.count_error);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
                  pending_rsp.size());
         $display("[urlencoded_form_decoder] ERROR");
         $finish;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      reset          = 1'b1;
      clear_decode_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_string();
      test_plain_pairs();
      test_escape_digits();
      test_cut_escape();
      test_backpressure();
      test_random_strings(0, 0, 110);
      test_random_strings(80, 0, 110);
      test_random_strings(0, 80, 110);
      test_random_strings(36, 36, 110);
      test_empty_string();

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("sent %0d bytes and ends in %0d strings, checked %0d results", items_sent,
               strings_sent, results_checked);
      $display("covered escapes, cut escapes, empty strings, long hold-off and stalls");
      if (error_count == 0) begin
         $display("[urlencoded_form_decoder] OK");
      end else begin
         $display("[urlencoded_form_decoder] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ufd_pkg.sv
rtl/ufd_stream_if.sv
rtl/ufd_front.sv
rtl/ufd_queue.sv
rtl/ufd_back.sv
rtl/urlencoded_form_decoder.sv
verif/urlencoded_form_decoder_tb.sv
